@@ rtl/tvwp_pkg.sv @@
// ----------------------------------------------------------------------------
// Typed value wire parser package
// Shared types, codes and the wire type byte map for the parser blocks.
// ----------------------------------------------------------------------------
package tvwp_pkg;

  localparam int LEN_W    = 32;
  localparam int LEB_W    = $clog2(LEN_W + 8);
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [15:0] REV_3_0 = 16'h0300;

  localparam logic [3:0] TY_BOOL    = 4'd0;
  localparam logic [3:0] TY_DOUBLE  = 4'd1;
  localparam logic [3:0] TY_STRING  = 4'd2;
  localparam logic [3:0] TY_RAW     = 4'd3;
  localparam logic [3:0] TY_BOOLARR = 4'd4;
  localparam logic [3:0] TY_DBLARR  = 4'd5;
  localparam logic [3:0] TY_STRARR  = 4'd6;
  localparam logic [3:0] TY_RPC     = 4'd7;

  typedef enum logic [1:0] {
    CMD_TYPE  = 2'd0,
    CMD_GIVEN = 2'd1,
    CMD_DATA  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_FAIL  = 2'd1,
    OP_DATA  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    K_PEND  = 3'd0,
    K_TYPE  = 3'd1,
    K_BOOL  = 3'd2,
    K_DBL   = 3'd3,
    K_BYTE  = 3'd4,
    K_EMPTY = 3'd5,
    K_ERR   = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    E_NONE     = 3'd0,
    E_UNKNOWN  = 3'd1,
    E_RAW_OLD  = 3'd2,
    E_RPC_OLD  = 3'd3,
    E_INVALID  = 3'd4,
    E_OVERFLOW = 3'd5
  } err_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] ty;
    logic [7:0] data;
  } req_t;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] value_bits;
    logic [7:0]  element_index;
    logic [7:0]  array_count;
    logic        element_done;
    logic        value_done;
    err_e        error_code;
  } res_t;

  typedef struct packed {
    logic       known;
    logic [3:0] ty;
  } type_map_t;

  function automatic type_map_t map_type(input logic [7:0] b);
    type_map_t m;
    m.known = 1'b1;
    case (b)
      8'h00:   m.ty = TY_BOOL;
      8'h01:   m.ty = TY_DOUBLE;
      8'h02:   m.ty = TY_STRING;
      8'h03:   m.ty = TY_RAW;
      8'h10:   m.ty = TY_BOOLARR;
      8'h11:   m.ty = TY_DBLARR;
      8'h12:   m.ty = TY_STRARR;
      8'h20:   m.ty = TY_RPC;
      default: begin
        m.known = 1'b0;
        m.ty    = TY_BOOL;
      end
    endcase
    return m;
  endfunction

endpackage

@@ rtl/tvwp_front.sv @@
// ----------------------------------------------------------------------------
// Typed value wire parser front end
// Accepts input items, classifies them into parser requests and queues them.
// ----------------------------------------------------------------------------
module tvwp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  logic [1:0]     cmd_i,
  input  logic [7:0]     data_byte_i,
  input  logic [3:0]     given_type_i,
  output logic           req_valid_o,
  output tvwp_pkg::req_t req_o,
  input  logic           req_pop_i
);
  import tvwp_pkg::*;

  req_t              cls;
  type_map_t         tm;
  req_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              wr_en, rd_en;

  always_comb begin
    tm       = map_type(data_byte_i);
    cls.ty   = given_type_i;
    cls.data = data_byte_i;
    case (cmd_e'(cmd_i))
      CMD_TYPE: begin
        cls.op = tm.known ? OP_START : OP_FAIL;
        cls.ty = tm.ty;
      end
      CMD_GIVEN: cls.op = OP_START;
      CMD_DATA:  cls.op = OP_DATA;
      default:   cls.op = OP_NOP;
    endcase
  end

  assign full        = (cnt_q == QCNT_W'(QDEPTH));
  assign req_valid_o = (cnt_q != '0);
  assign req_o       = mem_q[rd_q];
  assign wr_en       = push && !full;
  assign rd_en       = req_pop_i && req_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= '0;
      rd_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en) begin
        wr_q <= wr_q + 1'b1;
      end
      if (rd_en) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= cls;
    end
  end

endmodule

@@ rtl/tvwp_back.sv @@
// ----------------------------------------------------------------------------
// Typed value wire parser back end
// Executes parser requests against the value state and queues the results.
// ----------------------------------------------------------------------------
module tvwp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [15:0]    protocol_revision_i,
  input  logic           req_valid_i,
  input  tvwp_pkg::req_t req_i,
  output logic           req_pop_o,
  output logic           empty,
  input  logic           pop,
  output tvwp_pkg::res_t res_o
);
  import tvwp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BOOL,
    PH_DBL,
    PH_COUNT,
    PH_LEN,
    PH_PAY
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [2:0]         type_q, type_d;
  logic [7:0]         count_q, count_d;
  logic [7:0]         index_q, index_d;
  logic [LEN_W-1:0]   length_q, length_d;
  logic [LEB_W-1:0]   leb_q, leb_d;
  logic [63:0]        accum_q, accum_d;
  logic [2:0]         bytes_q, bytes_d;

  res_t               res;
  logic               is_arr;
  logic [7:0]         total;
  logic               do_fin;
  kind_e              fin_kind;
  logic [63:0]        fin_val;
  logic               old_rev;
  logic [LEN_W+6:0]   leb_wide;
  logic [LEB_W:0]     leb_next;
  phase_e             elem_phase;

  res_t               mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_q, rd_q;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               res_full, wr_en, rd_en;

  assign is_arr   = (type_q == TY_BOOLARR[2:0]) || (type_q == TY_DBLARR[2:0]) ||
                    (type_q == TY_STRARR[2:0]);
  assign total    = index_q + count_q;
  assign old_rev  = (protocol_revision_i < REV_3_0);
  assign leb_wide = {{LEN_W{1'b0}}, req_i.data[6:0]} << leb_q;
  assign leb_next = {1'b0, leb_q} + (LEB_W + 1)'(7);

  always_comb begin
    case (type_q)
      TY_BOOLARR[2:0]: elem_phase = PH_BOOL;
      TY_DBLARR[2:0]:  elem_phase = PH_DBL;
      default:         elem_phase = PH_LEN;
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    type_d   = type_q;
    count_d  = count_q;
    index_d  = index_q;
    length_d = length_q;
    leb_d    = leb_q;
    accum_d  = accum_q;
    bytes_d  = bytes_q;
    res      = '0;
    res.kind = K_PEND;
    res.error_code = E_NONE;
    do_fin   = 1'b0;
    fin_kind = K_PEND;
    fin_val  = '0;

    case (req_i.op)
      OP_FAIL: begin
        phase_d        = PH_IDLE;
        res.kind       = K_ERR;
        res.error_code = E_UNKNOWN;
      end
      OP_START: begin
        type_d   = req_i.ty[2:0];
        count_d  = '0;
        index_d  = '0;
        length_d = '0;
        leb_d    = '0;
        accum_d  = '0;
        bytes_d  = '0;
        if (req_i.ty[3]) begin
          phase_d        = PH_IDLE;
          res.kind       = K_ERR;
          res.error_code = E_INVALID;
        end else if (old_rev && (req_i.ty == TY_RAW || req_i.ty == TY_RPC)) begin
          phase_d        = PH_IDLE;
          res.kind       = K_ERR;
          res.error_code = (req_i.ty == TY_RAW) ? E_RAW_OLD : E_RPC_OLD;
        end else begin
          res.kind = K_TYPE;
          case (req_i.ty)
            TY_BOOL:   phase_d = PH_BOOL;
            TY_DOUBLE: phase_d = PH_DBL;
            TY_BOOLARR, TY_DBLARR, TY_STRARR: phase_d = PH_COUNT;
            default:   phase_d = PH_LEN;
          endcase
        end
      end
      OP_DATA: begin
        res.element_index = is_arr ? index_q : 8'd0;
        res.array_count   = is_arr ? total : 8'd0;
        case (phase_q)
          PH_BOOL: begin
            do_fin   = 1'b1;
            fin_kind = K_BOOL;
            fin_val  = {63'd0, req_i.data != 8'd0};
          end
          PH_DBL: begin
            accum_d = {accum_q[55:0], req_i.data};
            if (bytes_q == 3'd7) begin
              bytes_d  = '0;
              do_fin   = 1'b1;
              fin_kind = K_DBL;
              fin_val  = accum_d;
            end else begin
              bytes_d = bytes_q + 3'd1;
            end
          end
          PH_COUNT: begin
            count_d  = req_i.data;
            index_d  = '0;
            length_d = '0;
            leb_d    = '0;
            accum_d  = '0;
            bytes_d  = '0;
            res.element_index = '0;
            if (req_i.data == 8'd0) begin
              phase_d         = PH_IDLE;
              res.array_count = '0;
              res.value_done  = 1'b1;
            end else begin
              phase_d         = elem_phase;
              res.array_count = is_arr ? req_i.data : 8'd0;
            end
          end
          PH_LEN: begin
            if (old_rev) begin
              if (bytes_q == 3'd0) begin
                length_d = LEN_W'({req_i.data, 8'd0});
                bytes_d  = 3'd1;
              end else begin
                length_d = length_q | LEN_W'(req_i.data);
                bytes_d  = '0;
                if (length_d == '0) begin
                  do_fin   = 1'b1;
                  fin_kind = K_EMPTY;
                end else begin
                  phase_d = PH_PAY;
                end
              end
            end else if ((leb_q >= LEB_W'(LEN_W) && req_i.data[6:0] != 7'd0) ||
                         (leb_q < LEB_W'(LEN_W) && leb_wide[LEN_W+6:LEN_W] != 7'd0)) begin
              phase_d           = PH_IDLE;
              res               = '0;
              res.kind          = K_ERR;
              res.error_code    = E_OVERFLOW;
            end else begin
              if (leb_q < LEB_W'(LEN_W)) begin
                length_d = length_q | leb_wide[LEN_W-1:0];
              end
              leb_d = (leb_next > (LEB_W + 1)'(LEN_W)) ? LEB_W'(LEN_W) : leb_next[LEB_W-1:0];
              if (!req_i.data[7]) begin
                leb_d = '0;
                if (length_d == '0) begin
                  do_fin   = 1'b1;
                  fin_kind = K_EMPTY;
                end else begin
                  phase_d = PH_PAY;
                end
              end
            end
          end
          PH_PAY: begin
            length_d = length_q - 1'b1;
            if (length_d == '0) begin
              do_fin   = 1'b1;
              fin_kind = K_BYTE;
              fin_val  = {56'd0, req_i.data};
            end else begin
              res.kind       = K_BYTE;
              res.value_bits = {56'd0, req_i.data};
            end
          end
          default: begin
            res = '0;
          end
        endcase
      end
      default: begin
        res = '0;
      end
    endcase

    if (do_fin) begin
      res.kind         = fin_kind;
      res.value_bits   = fin_val;
      res.element_done = 1'b1;
      res.value_done   = 1'b1;
      res.error_code   = E_NONE;
      res.element_index = '0;
      res.array_count   = '0;
      phase_d          = PH_IDLE;
      if (is_arr) begin
        res.element_index = index_q;
        res.array_count   = total;
        index_d           = index_q + 8'd1;
        count_d           = count_q - 8'd1;
        if (count_q != 8'd1) begin
          res.value_done = 1'b0;
          length_d       = '0;
          leb_d          = '0;
          accum_d        = '0;
          bytes_d        = '0;
          phase_d        = elem_phase;
        end
      end
    end
  end

  assign res_full  = (cnt_q == QCNT_W'(QDEPTH));
  assign req_pop_o = req_valid_i && !res_full;
  assign wr_en     = req_pop_o;
  assign empty     = (cnt_q == '0);
  assign rd_en     = pop && !empty;
  assign res_o     = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      type_q   <= '0;
      count_q  <= '0;
      index_q  <= '0;
      length_q <= '0;
      leb_q    <= '0;
      accum_q  <= '0;
      bytes_q  <= '0;
      cnt_q    <= '0;
      wr_q     <= '0;
      rd_q     <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en) begin
        phase_q  <= phase_d;
        type_q   <= type_d;
        count_q  <= count_d;
        index_q  <= index_d;
        length_q <= length_d;
        leb_q    <= leb_d;
        accum_q  <= accum_d;
        bytes_q  <= bytes_d;
        wr_q     <= wr_q + 1'b1;
      end
      if (rd_en) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= res;
    end
  end

endmodule

@@ rtl/typed_value_wire_parser_top.sv @@
// ----------------------------------------------------------------------------
// Typed value wire parser
// Each result is written to the result queue when the back end takes its request from the request queue.
// Throughput is one request per cycle while the result queue has room; the parser step is combinational.
// A two-entry request queue and a two-entry result queue decouple the sides.
// Reset clears both queues and the parser state; the revision becomes 0x0300.
// ----------------------------------------------------------------------------
module typed_value_wire_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  data_byte_i,
  input  logic [3:0]  given_type_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind_o,
  output logic [63:0] value_bits_o,
  output logic [7:0]  element_index_o,
  output logic [7:0]  array_count_o,
  output logic        element_done_o,
  output logic        value_done_o,
  output logic [2:0]  error_code_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import tvwp_pkg::*;

  logic [15:0] rev_q;
  logic        req_valid;
  logic        req_pop;
  req_t        req;
  res_t        res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rev_q <= REV_3_0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      rev_q <= cfg_data_i;
    end
  end

  tvwp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .cmd_i        (cmd_i),
    .data_byte_i  (data_byte_i),
    .given_type_i (given_type_i),
    .req_valid_o  (req_valid),
    .req_o        (req),
    .req_pop_i    (req_pop)
  );

  tvwp_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .protocol_revision_i (rev_q),
    .req_valid_i         (req_valid),
    .req_i               (req),
    .req_pop_o           (req_pop),
    .empty               (empty),
    .pop                 (pop),
    .res_o               (res)
  );

  assign kind_o          = res.kind;
  assign value_bits_o    = res.value_bits;
  assign element_index_o = res.element_index;
  assign array_count_o   = res.array_count;
  assign element_done_o  = res.element_done;
  assign value_done_o    = res.value_done;
  assign error_code_o    = res.error_code;

endmodule
